// ----- hdl/ralu_pkg.sv -----
// ============================================================================
// ralu_pkg
// Shared types, constants and helpers for the register ALU with status flags.
// ============================================================================
package ralu_pkg;

  localparam int REG_COUNT   = 8;
  localparam int REG_AW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int IDX_W       = 3;
  localparam int DATA_W      = 16;
  localparam int ACT_W       = 5;
  localparam int FLAG_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // status word bit positions
  localparam int FLG_C = 0;
  localparam int FLG_V = 1;
  localparam int FLG_N = 2;
  localparam int FLG_Z = 3;
  localparam int FLG_S = 4;

  localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00FF;
  localparam logic [DATA_W-1:0] WORD_MASK = 16'hFFFF;
  localparam logic [7:0]        HIGH_ONES = 8'hFF;

  // instruction codes on the input port
  localparam logic [ACT_W-1:0] ACT_SWAP  = 5'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 5'd1;
  localparam logic [ACT_W-1:0] ACT_ADDC  = 5'd2;
  localparam logic [ACT_W-1:0] ACT_SUB   = 5'd3;
  localparam logic [ACT_W-1:0] ACT_SUBC  = 5'd4;
  localparam logic [ACT_W-1:0] ACT_CMP   = 5'd5;
  localparam logic [ACT_W-1:0] ACT_XOR   = 5'd6;
  localparam logic [ACT_W-1:0] ACT_AND   = 5'd7;
  localparam logic [ACT_W-1:0] ACT_OR    = 5'd8;
  localparam logic [ACT_W-1:0] ACT_BIT   = 5'd9;
  localparam logic [ACT_W-1:0] ACT_BIC   = 5'd10;
  localparam logic [ACT_W-1:0] ACT_BIS   = 5'd11;
  localparam logic [ACT_W-1:0] ACT_MOV   = 5'd12;
  localparam logic [ACT_W-1:0] ACT_SWPB  = 5'd13;
  localparam logic [ACT_W-1:0] ACT_SRA   = 5'd14;
  localparam logic [ACT_W-1:0] ACT_RRC   = 5'd15;
  localparam logic [ACT_W-1:0] ACT_SXT   = 5'd16;
  localparam logic [ACT_W-1:0] ACT_MOVLZ = 5'd17;
  localparam logic [ACT_W-1:0] ACT_MOVL  = 5'd18;
  localparam logic [ACT_W-1:0] ACT_MOVLS = 5'd19;
  localparam logic [ACT_W-1:0] ACT_MOVH  = 5'd20;
  localparam logic [ACT_W-1:0] ACT_SETCC = 5'd21;
  localparam logic [ACT_W-1:0] ACT_CLRCC = 5'd22;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SWAP,
    OP_ADD,
    OP_ADDC,
    OP_SUB,
    OP_SUBC,
    OP_CMP,
    OP_XOR,
    OP_AND,
    OP_OR,
    OP_BIT,
    OP_BIC,
    OP_BIS,
    OP_MOV,
    OP_SWPB,
    OP_SRA,
    OP_RRC,
    OP_SXT,
    OP_MOVLZ,
    OP_MOVL,
    OP_MOVLS,
    OP_MOVH,
    OP_SETCC,
    OP_CLRCC
  } op_e;

  // classified instruction word, as it sits in the queue
  typedef struct packed {
    op_e               op;
    logic              byte_en;  // low byte only, already gated by op
    logic              wr_dst;   // single write of the destination
    logic [IDX_W-1:0]  dst;
    logic [IDX_W-1:0]  src;
    logic [DATA_W-1:0] operand;
    logic [FLAG_W-1:0] flag_mask;
  } item_t;

  function automatic logic reg_in_range(input logic [IDX_W-1:0] idx);
    return (int'(idx) < REG_COUNT);
  endfunction

  function automatic logic [REG_AW-1:0] reg_addr(input logic [IDX_W-1:0] idx);
    return REG_AW'(idx);
  endfunction

endpackage

// ----- hdl/ralu_ram.sv -----
// ============================================================================
// ralu_ram
// Generic RAM: one write port, two read ports, registered read (read-first).
// ============================================================================
module ralu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                           rdata_a_o,
  output logic [WIDTH-1:0]                           rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/ralu_front.sv -----
// ============================================================================
// ralu_front
// Input side: takes a word when the queue has room and classifies it.
// ============================================================================
module ralu_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ralu_pkg::ACT_W-1:0]     action_i,
  input  logic [ralu_pkg::IDX_W-1:0]     dst_reg_i,
  input  logic [ralu_pkg::IDX_W-1:0]     src_reg_i,
  input  logic [ralu_pkg::DATA_W-1:0]    operand_value_i,
  input  logic                           byte_mode_i,
  input  logic [ralu_pkg::FLAG_W-1:0]    flag_mask_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output ralu_pkg::item_t                q_item_o
);

  ralu_pkg::op_e op;
  logic          honors_byte;
  logic          wr_dst;

  always_comb begin
    op          = ralu_pkg::OP_NOP;
    honors_byte = 1'b0;
    wr_dst      = 1'b1;
    case (action_i)
      ralu_pkg::ACT_SWAP:  begin op = ralu_pkg::OP_SWAP;  wr_dst = 1'b0;      end
      ralu_pkg::ACT_ADD:   begin op = ralu_pkg::OP_ADD;   honors_byte = 1'b1; end
      ralu_pkg::ACT_ADDC:  begin op = ralu_pkg::OP_ADDC;  honors_byte = 1'b1; end
      ralu_pkg::ACT_SUB:   begin op = ralu_pkg::OP_SUB;   honors_byte = 1'b1; end
      ralu_pkg::ACT_SUBC:  begin op = ralu_pkg::OP_SUBC;  honors_byte = 1'b1; end
      ralu_pkg::ACT_CMP:   begin
        op = ralu_pkg::OP_CMP;
        honors_byte = 1'b1;
        wr_dst = 1'b0;
      end
      ralu_pkg::ACT_XOR:   begin op = ralu_pkg::OP_XOR;   honors_byte = 1'b1; end
      ralu_pkg::ACT_AND:   begin op = ralu_pkg::OP_AND;   honors_byte = 1'b1; end
      ralu_pkg::ACT_OR:    begin op = ralu_pkg::OP_OR;    honors_byte = 1'b1; end
      ralu_pkg::ACT_BIT:   begin
        op = ralu_pkg::OP_BIT;
        honors_byte = 1'b1;
        wr_dst = 1'b0;
      end
      ralu_pkg::ACT_BIC:   begin op = ralu_pkg::OP_BIC;   honors_byte = 1'b1; end
      ralu_pkg::ACT_BIS:   begin op = ralu_pkg::OP_BIS;   honors_byte = 1'b1; end
      ralu_pkg::ACT_MOV:   begin op = ralu_pkg::OP_MOV;   honors_byte = 1'b1; end
      ralu_pkg::ACT_SWPB:  begin op = ralu_pkg::OP_SWPB;                      end
      ralu_pkg::ACT_SRA:   begin op = ralu_pkg::OP_SRA;   honors_byte = 1'b1; end
      ralu_pkg::ACT_RRC:   begin op = ralu_pkg::OP_RRC;   honors_byte = 1'b1; end
      ralu_pkg::ACT_SXT:   begin op = ralu_pkg::OP_SXT;                       end
      ralu_pkg::ACT_MOVLZ: begin op = ralu_pkg::OP_MOVLZ;                     end
      ralu_pkg::ACT_MOVL:  begin op = ralu_pkg::OP_MOVL;                      end
      ralu_pkg::ACT_MOVLS: begin op = ralu_pkg::OP_MOVLS;                     end
      ralu_pkg::ACT_MOVH:  begin op = ralu_pkg::OP_MOVH;                      end
      ralu_pkg::ACT_SETCC: begin op = ralu_pkg::OP_SETCC; wr_dst = 1'b0;      end
      ralu_pkg::ACT_CLRCC: begin op = ralu_pkg::OP_CLRCC; wr_dst = 1'b0;      end
      default:             begin op = ralu_pkg::OP_NOP;   wr_dst = 1'b0;      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_item_o.op        = op;
    q_item_o.byte_en   = honors_byte & byte_mode_i;
    q_item_o.wr_dst    = wr_dst;
    q_item_o.dst       = dst_reg_i;
    q_item_o.src       = src_reg_i;
    q_item_o.operand   = operand_value_i;
    q_item_o.flag_mask = flag_mask_i;
  end

endmodule

// ----- hdl/ralu_queue.sv -----
// ============================================================================
// ralu_queue
// Short FIFO of classified words between the front and the execute side.
// ============================================================================
module ralu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ralu_pkg::item_t item_i,
  output logic            full_o,
  output logic            vld_o,
  output ralu_pkg::item_t item_o,
  input  logic            pop_i
);

  ralu_pkg::item_t                    mem_q [ralu_pkg::QUEUE_DEPTH];
  logic [ralu_pkg::QUEUE_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ralu_pkg::QUEUE_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ralu_pkg::QUEUE_CW-1:0]      cnt_q, cnt_d;
  logic                               do_pop;

  assign full_o = (cnt_q == ralu_pkg::QUEUE_CW'(ralu_pkg::QUEUE_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign item_o = mem_q[rd_ptr_q];
  assign do_pop = pop_i & vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ralu_pkg::QUEUE_AW'(ralu_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ralu_pkg::QUEUE_AW'(ralu_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/ralu_back.sv -----
// ============================================================================
// ralu_back
// Execute side: register file read, ALU, flag update, write back, result word.
// ============================================================================
module ralu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_vld_i,
  input  ralu_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ralu_pkg::DATA_W-1:0]   dst_value_o,
  output logic [ralu_pkg::DATA_W-1:0]   src_value_o,
  output logic [ralu_pkg::FLAG_W-1:0]   flags_o
);

  // execute stage
  logic                                 x_vld_q;
  logic                                 x_phase_q;
  ralu_pkg::item_t                      x_item_q;
  logic                                 rd_vld_a_q, rd_vld_b_q;
  logic                                 issue, x_done, x_swap1, out_free, is_swap;

  // register file
  logic [ralu_pkg::REG_COUNT-1:0]       reg_vld_q;
  logic [ralu_pkg::DATA_W-1:0]          rdata_a, rdata_b;
  logic                                 ram_we;
  logic [ralu_pkg::IDX_W-1:0]           wr_idx;
  logic [ralu_pkg::DATA_W-1:0]          ram_wdata;

  // bypass of the last completed write
  logic                                 byp_vld_q;
  logic [ralu_pkg::IDX_W-1:0]           byp_idx_q;
  logic [ralu_pkg::DATA_W-1:0]          byp_data_q;

  logic [ralu_pkg::FLAG_W-1:0]          flags_q, flags_d;

  logic                                 d_in, s_in;
  logic [ralu_pkg::DATA_W-1:0]          old_d, old_s;
  logic [ralu_pkg::DATA_W-1:0]          mask, a, b, r, new_d;
  logic [ralu_pkg::DATA_W:0]            sum, diff;
  logic                                 cin, c_add, c_sub;
  logic                                 upd_c, upd_v, upd_zn, c_new, v_new, z_new, n_new;
  logic [ralu_pkg::DATA_W-1:0]          dst_res, src_res;

  logic                                 out_vld_q;
  logic [ralu_pkg::DATA_W-1:0]          out_dst_q, out_src_q;
  logic [ralu_pkg::FLAG_W-1:0]          out_flags_q;

  assign is_swap  = (x_item_q.op == ralu_pkg::OP_SWAP);
  assign out_free = ~out_vld_q | ~out_stall_i;
  assign x_swap1  = x_vld_q & is_swap & ~x_phase_q;
  assign x_done   = x_vld_q & (~is_swap | x_phase_q) & out_free;
  assign issue    = q_vld_i & (~x_vld_q | x_done);
  assign q_pop_o  = issue;

  ralu_ram #(
    .WIDTH (ralu_pkg::DATA_W),
    .DEPTH (ralu_pkg::REG_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ralu_pkg::reg_addr(wr_idx)),
    .wdata_i   (ram_wdata),
    .re_i      (issue),
    .raddr_a_i (ralu_pkg::reg_addr(q_item_i.dst)),
    .raddr_b_i (ralu_pkg::reg_addr(q_item_i.src)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // operand fetch: out-of-range reads 0, unwritten entries read 0
  always_comb begin
    d_in = ralu_pkg::reg_in_range(x_item_q.dst);
    s_in = ralu_pkg::reg_in_range(x_item_q.src);
    if (!d_in) begin
      old_d = '0;
    end else if (byp_vld_q && (byp_idx_q == x_item_q.dst)) begin
      old_d = byp_data_q;
    end else begin
      old_d = rd_vld_a_q ? rdata_a : '0;
    end
    if (!s_in) begin
      old_s = '0;
    end else if (byp_vld_q && (byp_idx_q == x_item_q.src)) begin
      old_s = byp_data_q;
    end else begin
      old_s = rd_vld_b_q ? rdata_b : '0;
    end
  end

  // ALU
  always_comb begin
    mask  = x_item_q.byte_en ? ralu_pkg::BYTE_MASK : ralu_pkg::WORD_MASK;
    a     = old_d & mask;
    b     = x_item_q.operand & mask;
    cin   = flags_q[ralu_pkg::FLG_C];
    c_add = (x_item_q.op == ralu_pkg::OP_ADDC) & cin;
    c_sub = (x_item_q.op == ralu_pkg::OP_SUBC) & cin;
    sum   = {1'b0, a} + {1'b0, b} + {{ralu_pkg::DATA_W{1'b0}}, c_add};
    diff  = {1'b0, a} - {1'b0, b} - {{ralu_pkg::DATA_W{1'b0}}, c_sub};
    r      = '0;
    upd_c  = 1'b0;
    upd_v  = 1'b0;
    upd_zn = 1'b0;
    c_new  = 1'b0;
    v_new  = 1'b0;
    case (x_item_q.op)
      ralu_pkg::OP_ADD, ralu_pkg::OP_ADDC: begin
        r      = sum[ralu_pkg::DATA_W-1:0] & mask;
        upd_c  = 1'b1;
        upd_v  = 1'b1;
        upd_zn = 1'b1;
        c_new  = x_item_q.byte_en ? sum[8] : sum[ralu_pkg::DATA_W];
        v_new  = x_item_q.byte_en ? ((a[7] ^ r[7]) & (b[7] ^ r[7]))
                                  : ((a[15] ^ r[15]) & (b[15] ^ r[15]));
      end
      ralu_pkg::OP_SUB, ralu_pkg::OP_SUBC, ralu_pkg::OP_CMP: begin
        r      = diff[ralu_pkg::DATA_W-1:0] & mask;
        upd_c  = 1'b1;
        upd_v  = 1'b1;
        upd_zn = 1'b1;
        c_new  = diff[ralu_pkg::DATA_W];  // borrow
        v_new  = x_item_q.byte_en ? ((a[7] ^ b[7]) & (a[7] ^ r[7]))
                                  : ((a[15] ^ b[15]) & (a[15] ^ r[15]));
      end
      ralu_pkg::OP_XOR: begin r = a ^ b;         upd_zn = 1'b1; end
      ralu_pkg::OP_AND, ralu_pkg::OP_BIT: begin
        r = a & b;
        upd_zn = 1'b1;
      end
      ralu_pkg::OP_OR, ralu_pkg::OP_BIS: begin
        r = a | b;
        upd_zn = 1'b1;
      end
      ralu_pkg::OP_BIC: begin r = a & ~b & mask; upd_zn = 1'b1; end
      ralu_pkg::OP_MOV: begin r = b;             upd_zn = 1'b1; end
      ralu_pkg::OP_SWPB: begin
        r      = {old_d[7:0], old_d[15:8]};
        upd_zn = 1'b1;
      end
      ralu_pkg::OP_SRA: begin
        r = x_item_q.byte_en ? {8'h00, a[7], a[7:1]} : {a[15], a[15:1]};
        upd_zn = 1'b1;
      end
      ralu_pkg::OP_RRC: begin
        r = x_item_q.byte_en ? {8'h00, cin, a[7:1]} : {cin, a[15:1]};
        upd_c  = 1'b1;
        upd_zn = 1'b1;
        c_new  = a[0];
      end
      ralu_pkg::OP_SXT: begin
        r      = {{8{old_d[7]}}, old_d[7:0]};
        upd_zn = 1'b1;
      end
      ralu_pkg::OP_MOVLZ: r = {8'h00, x_item_q.operand[7:0]};
      ralu_pkg::OP_MOVL:  r = {old_d[15:8], x_item_q.operand[7:0]};
      ralu_pkg::OP_MOVLS: r = {ralu_pkg::HIGH_ONES, x_item_q.operand[7:0]};
      ralu_pkg::OP_MOVH:  r = {x_item_q.operand[7:0], old_d[7:0]};
      default:            r = '0;
    endcase

    // swpb tests the new low byte only
    if (x_item_q.op == ralu_pkg::OP_SWPB) begin
      z_new = (r[7:0] == 8'h00);
      n_new = r[7];
    end else begin
      z_new = ((r & mask) == '0);
      n_new = x_item_q.byte_en ? r[7] : r[15];
    end

    new_d = x_item_q.byte_en ? {old_d[15:8], r[7:0]} : r;

    flags_d = flags_q;
    if (upd_c)  flags_d[ralu_pkg::FLG_C] = c_new;
    if (upd_v)  flags_d[ralu_pkg::FLG_V] = v_new;
    if (upd_zn) begin
      flags_d[ralu_pkg::FLG_Z] = z_new;
      flags_d[ralu_pkg::FLG_N] = n_new;
    end
    if (x_item_q.op == ralu_pkg::OP_SETCC) flags_d = flags_q | x_item_q.flag_mask;
    if (x_item_q.op == ralu_pkg::OP_CLRCC) flags_d = flags_q & ~x_item_q.flag_mask;
  end

  // result word and write-back
  always_comb begin
    if (is_swap) begin
      dst_res = !d_in ? '0 : ((x_item_q.dst == x_item_q.src) ? old_d : old_s);
      src_res = !s_in ? '0 : old_d;
    end else begin
      dst_res = !d_in ? '0 : (x_item_q.wr_dst ? new_d : old_d);
      src_res = !s_in ? '0 :
                ((x_item_q.wr_dst && (x_item_q.src == x_item_q.dst)) ? new_d : old_s);
    end

    ram_we    = 1'b0;
    wr_idx    = x_item_q.dst;
    ram_wdata = new_d;
    if (x_swap1) begin
      // swap, first half: dst takes the old src
      ram_we    = d_in;
      wr_idx    = x_item_q.dst;
      ram_wdata = old_s;
    end else if (x_done) begin
      if (is_swap) begin
        ram_we    = s_in;
        wr_idx    = x_item_q.src;
        ram_wdata = old_d;
      end else begin
        ram_we    = x_item_q.wr_dst & d_in;
        wr_idx    = x_item_q.dst;
        ram_wdata = new_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q    <= 1'b0;
      x_phase_q  <= 1'b0;
      rd_vld_a_q <= 1'b0;
      rd_vld_b_q <= 1'b0;
      reg_vld_q  <= '0;
      byp_vld_q  <= 1'b0;
      byp_idx_q  <= '0;
      flags_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (issue) begin
        x_vld_q    <= 1'b1;
        rd_vld_a_q <= reg_vld_q[ralu_pkg::reg_addr(q_item_i.dst)] &
                      ralu_pkg::reg_in_range(q_item_i.dst);
        rd_vld_b_q <= reg_vld_q[ralu_pkg::reg_addr(q_item_i.src)] &
                      ralu_pkg::reg_in_range(q_item_i.src);
      end else if (x_done) begin
        x_vld_q <= 1'b0;
      end
      if (x_swap1) begin
        x_phase_q <= 1'b1;
      end else if (x_done) begin
        x_phase_q <= 1'b0;
      end
      if (ram_we) begin
        reg_vld_q[ralu_pkg::reg_addr(wr_idx)] <= 1'b1;
      end
      // only the final write of a word is bypassed; earlier ones are in the RAM
      if (x_done) begin
        byp_vld_q <= ram_we;
        byp_idx_q <= wr_idx;
        flags_q   <= flags_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      x_item_q <= q_item_i;
    end
    if (x_done) begin
      byp_data_q  <= ram_wdata;
      out_dst_q   <= dst_res;
      out_src_q   <= src_res;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign dst_value_o = out_dst_q;
  assign src_value_o = out_src_q;
  assign flags_o     = out_flags_q;

endmodule

// ----- hdl/register_alu_with_status_flags.sv -----
// ============================================================================
// register_alu_with_status_flags
// Sixteen-bit register ALU with an 8-entry register file and status flags.
// ============================================================================
//
//  channel  | handshake               | word
//  ---------+-------------------------+-----------------------------------------
//  in       | in_valid_i / in_stall_o | action, dst/src reg, operand, byte, mask
//  out      | out_valid_o/ out_stall_i| dst/src value, C Z N V S flags
//
//  One word per cycle while the output is not stalled; a swap holds the execute
//  stage for a second write, since the register file has a single write port.
//  From input to result a word passes the queue, the register file read and
//  the execute stage into the output register. Reset clears the register file
//  valid bits and the flags, so all registers read zero. A stalled output holds
//  the execute stage; the two-entry queue keeps taking input until it fills.
//
module register_alu_with_status_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  action_i,
  input  logic [2:0]  dst_reg_i,
  input  logic [2:0]  src_reg_i,
  input  logic [15:0] operand_value_i,
  input  logic        byte_mode_i,
  input  logic [4:0]  flag_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] dst_value_o,
  output logic [15:0] src_value_o,
  output logic        carry_flag_o,
  output logic        zero_flag_o,
  output logic        negative_flag_o,
  output logic        overflow_flag_o,
  output logic        sleep_flag_o
);

  logic                             q_full, q_push, q_vld, q_pop;
  ralu_pkg::item_t                  push_item, head_item;
  logic [ralu_pkg::FLAG_W-1:0]      flags;

  ralu_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .dst_reg_i       (dst_reg_i),
    .src_reg_i       (src_reg_i),
    .operand_value_i (operand_value_i),
    .byte_mode_i     (byte_mode_i),
    .flag_mask_i     (flag_mask_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  ralu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .vld_o  (q_vld),
    .item_o (head_item),
    .pop_i  (q_pop)
  );

  ralu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dst_value_o (dst_value_o),
    .src_value_o (src_value_o),
    .flags_o     (flags)
  );

  assign carry_flag_o    = flags[ralu_pkg::FLG_C];
  assign zero_flag_o     = flags[ralu_pkg::FLG_Z];
  assign negative_flag_o = flags[ralu_pkg::FLG_N];
  assign overflow_flag_o = flags[ralu_pkg::FLG_V];
  assign sleep_flag_o    = flags[ralu_pkg::FLG_S];

endmodule
